// ===== rtl/amsp_pkg.sv =====
package amsp_pkg;

	localparam int SLOTS   = 128;
	localparam int TARGETS = 32;

	localparam int KNOWN_W = (TARGETS > 1) ? $clog2(TARGETS) : 1;

	localparam logic FUNC_SEND = 1'b0;
	localparam logic FUNC_RECV = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic [7:0] COUNT_MAX = 8'hFF;

	typedef logic        [4:0]  proc_t;
	typedef logic        [7:0]  count_t;
	typedef logic signed [31:0] ident_t;
	typedef logic signed [63:0] value_t;

	typedef struct packed {
		logic   func;
		proc_t  target;
		logic   found;
		count_t count;
		ident_t ident;
		value_t value;
	} tok_t;

	typedef struct packed {
		logic [1:0] status;
		count_t     pending_count;
		logic       delivered;
		ident_t     delivered_id;
		value_t     delivered_param;
	} rsp_t;

endpackage

// ===== rtl/amsp_if.sv =====
interface amsp_req_if import amsp_pkg::*; ;
	logic   valid;
	logic   ready;
	logic   func;
	proc_t  peer;
	ident_t msg_id;
	value_t msg_param;

	modport source (output valid, func, peer, msg_id, msg_param, input ready);
	modport sink   (input valid, func, peer, msg_id, msg_param, output ready);
endinterface

interface amsp_rsp_if import amsp_pkg::*; ;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	count_t     pending_count;
	logic       delivered;
	ident_t     delivered_id;
	value_t     delivered_param;

	modport source (output valid, status, pending_count, delivered, delivered_id,
		delivered_param, input ready);
	modport sink   (input valid, status, pending_count, delivered, delivered_id,
		delivered_param, output ready);
endinterface

// ===== rtl/addressed_mailbox_slot_pool_core.sv =====
// Shared pool of message slots, each addressed to one receiver.
// Request channel (req): func selects send or receive, peer names the
// destination (send) or the receiver itself (receive), msg_id and msg_param
// are the message stored on send. Response channel (rsp): one transaction
// per request with status, pending_count, delivered, delivered_id and
// delivered_param.
// Each slot lives in one cell of a chain. An accepted request travels the
// chain one cell per cycle: a send claims the first free cell, a receive
// counts matching cells and empties the first one. Only one request is in
// the chain at a time: its response leaves the last cell and is registered
// in the output register, and the next request is taken only once it has
// left the chain.
// A send to an unknown or out-of-range receiver, and an out-of-range
// receive, bypass the chain and go straight to the response registers.
// Reset empties every slot and forgets every receiver.
// When rsp stalls, the response holds in the output register and one more
// request may be taken; its response parks in a second register, and req
// stays low until that one has moved to the output.
module addressed_mailbox_slot_pool_core import amsp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	amsp_req_if.sink   req,
	amsp_rsp_if.source rsp
);

	logic [TARGETS-1:0] known_q;
	logic               run_q;
	logic               out_vld_q;
	rsp_t               out_q;
	logic               pend_vld_q;
	rsp_t               pend_q;

	logic               chain_vld [SLOTS+1];
	tok_t               chain_tok [SLOTS+1];

	logic               accept;
	logic               in_range;
	logic [KNOWN_W-1:0] known_idx;
	logic               dest_known;
	logic               bypass;
	logic               launch;
	logic               tail_vld;
	tok_t               tail_tok;
	logic               done_vld;
	rsp_t               done_rsp;
	rsp_t               bypass_rsp;
	rsp_t               tail_rsp;

	assign req.ready = !run_q && !pend_vld_q;
	assign accept    = req.valid && req.ready;

	always_comb begin
		in_range   = (32'(req.peer) < TARGETS);
		known_idx  = KNOWN_W'(req.peer);
		dest_known = in_range && known_q[known_idx];
		bypass     = (req.func == FUNC_SEND) ? !dest_known : !in_range;
		launch     = accept && !bypass;

		bypass_rsp        = '0;
		bypass_rsp.status = (req.func == FUNC_SEND) ? ST_UNKNOWN : ST_OK;

		tail_rsp = '0;
		if (tail_tok.func == FUNC_SEND) begin
			tail_rsp.status = tail_tok.found ? ST_OK : ST_FULL;
		end else begin
			tail_rsp.status          = ST_OK;
			tail_rsp.pending_count   = tail_tok.count;
			tail_rsp.delivered       = tail_tok.found;
			tail_rsp.delivered_id    = tail_tok.found ? tail_tok.ident : '0;
			tail_rsp.delivered_param = tail_tok.found ? tail_tok.value : '0;
		end

		done_vld = tail_vld || (accept && bypass);
		done_rsp = tail_vld ? tail_rsp : bypass_rsp;
	end

	assign chain_vld[0]        = launch;
	assign chain_tok[0].func   = req.func;
	assign chain_tok[0].target = req.peer;
	assign chain_tok[0].found  = 1'b0;
	assign chain_tok[0].count  = '0;
	assign chain_tok[0].ident  = req.msg_id;
	assign chain_tok[0].value  = req.msg_param;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		amsp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.prev_valid(chain_vld[i]),
			.prev_tok  (chain_tok[i]),
			.next_valid(chain_vld[i+1]),
			.next_tok  (chain_tok[i+1])
		);
	end

	assign tail_vld = chain_vld[SLOTS];
	assign tail_tok = chain_tok[SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q    <= '0;
			run_q      <= 1'b0;
			out_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			if (accept && (req.func == FUNC_RECV) && in_range) begin
				known_q[known_idx] <= 1'b1;
			end
			if (launch) begin
				run_q <= 1'b1;
			end else if (tail_vld) begin
				run_q <= 1'b0;
			end
			if (done_vld) begin
				if (!out_vld_q || (rsp.ready && !pend_vld_q)) begin
					out_vld_q <= 1'b1;
				end else begin
					pend_vld_q <= 1'b1;
				end
			end else if (out_vld_q && rsp.ready) begin
				if (pend_vld_q) begin
					pend_vld_q <= 1'b0;
				end else begin
					out_vld_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_vld_q && rsp.ready && pend_vld_q) begin
			out_q <= pend_q;
		end
		if (done_vld) begin
			if (!out_vld_q || (rsp.ready && !pend_vld_q)) begin
				out_q <= done_rsp;
			end else begin
				pend_q <= done_rsp;
			end
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.status          = out_q.status;
	assign rsp.pending_count   = out_q.pending_count;
	assign rsp.delivered       = out_q.delivered;
	assign rsp.delivered_id    = out_q.delivered_id;
	assign rsp.delivered_param = out_q.delivered_param;

	a_tail_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		tail_vld |-> run_q)
		else $error("chain output without a request in flight");

	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> out_vld_q)
		else $error("parked response with empty output register");

	a_tail_lands: assert property (@(posedge clk) disable iff (!arst_n)
		tail_vld |=> out_vld_q)
		else $error("chain response dropped");

endmodule

// ===== rtl/amsp_cell.sv =====
module amsp_cell import amsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic prev_valid,
	input  tok_t prev_tok,
	output logic next_valid,
	output tok_t next_tok
);

	logic   busy_q;
	proc_t  target_q;
	ident_t ident_q;
	value_t value_q;
	logic   vld_q;
	tok_t   tok_q;

	logic hit;
	logic take;
	logic place;
	tok_t nxt;

	always_comb begin
		hit   = prev_valid && (prev_tok.func == FUNC_RECV) && busy_q &&
			(target_q == prev_tok.target);
		take  = hit && !prev_tok.found;
		place = prev_valid && (prev_tok.func == FUNC_SEND) && !prev_tok.found && !busy_q;
		nxt   = prev_tok;
		if (hit && (prev_tok.count != COUNT_MAX)) begin
			nxt.count = prev_tok.count + 8'd1;
		end
		if (take) begin
			nxt.found = 1'b1;
			nxt.ident = ident_q;
			nxt.value = value_q;
		end
		if (place) begin
			nxt.found = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			vld_q <= prev_valid;
			if (place) begin
				busy_q <= 1'b1;
			end else if (take) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= nxt;
		if (place) begin
			target_q <= prev_tok.target;
			ident_q  <= prev_tok.ident;
			value_q  <= prev_tok.value;
		end
	end

	assign next_valid = vld_q;
	assign next_tok   = tok_q;

	a_place_fills: assert property (@(posedge clk) disable iff (!arst_n)
		place |=> busy_q)
		else $error("slot not filled after send");

	a_take_frees: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !busy_q)
		else $error("slot not freed after receive");

	a_found_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		prev_valid && prev_tok.found |=> next_valid && next_tok.found)
		else $error("found flag lost along the chain");

endmodule
